// File: rtl/sbct_pkg.sv
// Shared codes and types for the segment and box crossing test.
`timescale 1ns / 1ps
package sbct_pkg;

  localparam logic KIND_SEG = 1'b0;
  localparam logic KIND_BOX = 1'b1;

  // Pipeline control handed from the top level to the datapath parts.
  typedef struct packed {
    logic adv;
  } pipe_ctl_t;

endpackage

// File: rtl/sbct_seg_pipe.sv
// Segment pair datapath: differences, products, numerators, unit-ratio test.
`timescale 1ns / 1ps
module sbct_seg_pipe #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  sbct_pkg::pipe_ctl_t          ctl,
  input  logic signed [COORD_BITS-1:0] pt_a_x,
  input  logic signed [COORD_BITS-1:0] pt_a_y,
  input  logic signed [COORD_BITS-1:0] pt_b_x,
  input  logic signed [COORD_BITS-1:0] pt_b_y,
  input  logic signed [COORD_BITS-1:0] pt_c_x,
  input  logic signed [COORD_BITS-1:0] pt_c_y,
  input  logic signed [COORD_BITS-1:0] pt_d_x,
  input  logic signed [COORD_BITS-1:0] pt_d_y,
  output logic                         hit
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int NW = PW + 1;

  logic signed [DW-1:0] dx12, dy12, dx34, dy34, dx13, dy13;
  logic signed [PW-1:0] p_d1, p_d2, p_t1, p_t2, p_u1, p_u2;
  logic signed [NW-1:0] den, tn, un;

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      dx12 <= DW'(pt_a_x) - DW'(pt_b_x);
      dy12 <= DW'(pt_a_y) - DW'(pt_b_y);
      dx34 <= DW'(pt_c_x) - DW'(pt_d_x);
      dy34 <= DW'(pt_c_y) - DW'(pt_d_y);
      dx13 <= DW'(pt_a_x) - DW'(pt_c_x);
      dy13 <= DW'(pt_a_y) - DW'(pt_c_y);
      p_d1 <= PW'(dx12) * PW'(dy34);
      p_d2 <= PW'(dy12) * PW'(dx34);
      p_t1 <= PW'(dx13) * PW'(dy34);
      p_t2 <= PW'(dy13) * PW'(dx34);
      p_u1 <= PW'(dy12) * PW'(dx13);
      p_u2 <= PW'(dx12) * PW'(dy13);
      den  <= NW'(p_d1) - NW'(p_d2);
      tn   <= NW'(p_t1) - NW'(p_t2);
      un   <= NW'(p_u1) - NW'(p_u2);
    end
  end

  logic t_ok, u_ok;

  // Ratio in [0,1] judged on the sign of den; zero den never hits.
  always_comb begin
    if (den > 0) begin
      t_ok = (tn >= 0) && (tn <= den);
      u_ok = (un >= 0) && (un <= den);
    end else begin
      t_ok = (tn <= 0) && (tn >= den);
      u_ok = (un <= 0) && (un >= den);
    end
    hit = (den != '0) && t_ok && u_ok;
  end

endmodule

// File: rtl/sbct_box_pipe.sv
// Box pair datapath: corners, axis-aligned edge overlap, edge-pair hit.
`timescale 1ns / 1ps
module sbct_box_pipe #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  sbct_pkg::pipe_ctl_t          ctl,
  input  logic signed [COORD_BITS-1:0] pt_a_x,
  input  logic signed [COORD_BITS-1:0] pt_a_y,
  input  logic signed [COORD_BITS-1:0] pt_b_x,
  input  logic signed [COORD_BITS-1:0] pt_b_y,
  input  logic signed [COORD_BITS-1:0] pt_c_x,
  input  logic signed [COORD_BITS-1:0] pt_c_y,
  input  logic signed [COORD_BITS-1:0] pt_d_x,
  input  logic signed [COORD_BITS-1:0] pt_d_y,
  output logic                         hit
);

  localparam int CW = COORD_BITS + 1;

  // Stage 1: corners. Box 1 spans x [ax,ax2], y [ay,ay2]; box 2 likewise.
  logic signed [CW-1:0] ax, ax2, ay, ay2, cx, cx2, cy, cy2;
  logic                 bx_nz, by_nz, dx_nz, dy_nz;

  // Stage 2: overlap bits and edge-length flags.
  logic [1:0] inx_a, iny_c, inx_c, iny_a;
  logic       v1h2, v2h1;

  function automatic logic between(input logic signed [CW-1:0] v,
                                   input logic signed [CW-1:0] e0,
                                   input logic signed [CW-1:0] e1);
    between = ((v >= e0) && (v <= e1)) || ((v >= e1) && (v <= e0));
  endfunction

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      ax    <= CW'(pt_a_x);
      ay    <= CW'(pt_a_y);
      ax2   <= CW'(pt_a_x) + CW'(pt_b_y);
      ay2   <= CW'(pt_a_y) + CW'(pt_b_x);
      cx    <= CW'(pt_c_x);
      cy    <= CW'(pt_c_y);
      cx2   <= CW'(pt_c_x) + CW'(pt_d_y);
      cy2   <= CW'(pt_c_y) + CW'(pt_d_x);
      bx_nz <= (pt_b_x != '0);
      by_nz <= (pt_b_y != '0);
      dx_nz <= (pt_d_x != '0);
      dy_nz <= (pt_d_y != '0);

      // box 1 verticals against box 2 horizontals, and the reverse
      inx_a <= {between(ax2, cx, cx2), between(ax, cx, cx2)};
      iny_c <= {between(cy2, ay, ay2), between(cy, ay, ay2)};
      inx_c <= {between(cx2, ax, ax2), between(cx, ax, ax2)};
      iny_a <= {between(ay2, cy, cy2), between(ay, cy, cy2)};
      v1h2  <= bx_nz && dy_nz;
      v2h1  <= dx_nz && by_nz;

      // parallel edge pairs are not tested and never hit
      hit <= (v1h2 && (|inx_a) && (|iny_c)) || (v2h1 && (|inx_c) && (|iny_a));
    end
  end

endmodule

// File: rtl/segment_and_box_crossing_test.sv
// Top level of the segment and box crossing test pipeline.
`timescale 1ns / 1ps
//
// channel | direction | handshake            | payload
// --------+-----------+----------------------+-----------------------------------
// input   | in        | in_valid / in_stall  | kind, pt_a..pt_d x and y
// result  | out       | out_valid / out_stall| hit
//
// Four register stages: three in the datapath (differences, products,
// numerators for segments; corners, overlap bits, edge-pair hit for boxes)
// and the output register. One transaction enters per cycle unless a result
// is stalled. The segment unit's multiplier stage forms six 17x17 products.
// Reset clears the stage valid bits only. A stalled result freezes the whole
// pipeline, so in_stall follows out_stall while out_valid is high.
module segment_and_box_crossing_test #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         kind,
  input  logic signed [COORD_BITS-1:0] pt_a_x,
  input  logic signed [COORD_BITS-1:0] pt_a_y,
  input  logic signed [COORD_BITS-1:0] pt_b_x,
  input  logic signed [COORD_BITS-1:0] pt_b_y,
  input  logic signed [COORD_BITS-1:0] pt_c_x,
  input  logic signed [COORD_BITS-1:0] pt_c_y,
  input  logic signed [COORD_BITS-1:0] pt_d_x,
  input  logic signed [COORD_BITS-1:0] pt_d_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         hit
);

  sbct_pkg::pipe_ctl_t ctl;
  logic                v1, v2, v3;
  logic                kind1, kind2, kind3;
  logic                seg_hit, box_hit;

  // Whole pipe moves unless a finished result is held up.
  assign ctl.adv  = !(out_valid && out_stall);
  assign in_stall = !ctl.adv;

  sbct_seg_pipe #(.COORD_BITS(COORD_BITS)) u_seg (
    .clk(clk), .ctl(ctl),
    .pt_a_x(pt_a_x), .pt_a_y(pt_a_y), .pt_b_x(pt_b_x), .pt_b_y(pt_b_y),
    .pt_c_x(pt_c_x), .pt_c_y(pt_c_y), .pt_d_x(pt_d_x), .pt_d_y(pt_d_y),
    .hit(seg_hit)
  );

  sbct_box_pipe #(.COORD_BITS(COORD_BITS)) u_box (
    .clk(clk), .ctl(ctl),
    .pt_a_x(pt_a_x), .pt_a_y(pt_a_y), .pt_b_x(pt_b_x), .pt_b_y(pt_b_y),
    .pt_c_x(pt_c_x), .pt_c_y(pt_c_y), .pt_d_x(pt_d_x), .pt_d_y(pt_d_y),
    .hit(box_hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (ctl.adv) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  // payload side: no reset needed
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      kind1 <= kind;
      kind2 <= kind1;
      kind3 <= kind2;
      hit   <= (kind3 == sbct_pkg::KIND_BOX) ? box_hit : seg_hit;
    end
  end

endmodule
